FILE: design/bmr_pkg.sv
// Shared definitions for the bitmap line rasterizer: stream layout, codes,
// default sizes and the store sizing function. No dependencies.

package bmr_pkg;

    localparam int IMAGE_SIDE_DEF = 256;
    localparam int COORD_W        = 16;
    localparam int RADDR_W        = 13;
    localparam int DATA_W         = 8;

    localparam int SX_LSB    = 0;
    localparam int SY_LSB    = 16;
    localparam int EX_LSB    = 32;
    localparam int EY_LSB    = 48;
    localparam int RA_LSB    = 64;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam int   APB_ADDR_W    = 3;
    localparam logic REG_LANDSCAPE = 1'b0;

    function automatic int store_bytes(input int side);
        return side * ((side + 7) / 8);
    endfunction

    localparam int MEM_DEPTH_DEF = store_bytes(IMAGE_SIDE_DEF);

endpackage

FILE: design/bmr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on bmr_pkg for default sizes.

module bmr_ram import bmr_pkg::*; #(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = MEM_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/bmr_engine.sv
// Control and datapath of the rasterizer: clearing pass, segment setup,
// Bresenham walk with read-modify-write of the store, reads and the result
// register. Depends on bmr_pkg; drives the ports of one bmr_ram.

module bmr_engine import bmr_pkg::*; #(
    parameter int IMAGE_SIDE = IMAGE_SIDE_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    landscape,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [S_TDATA_W-1:0]                    s_tdata,
    input  logic [0:0]                              s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [M_TDATA_W-1:0]                    m_tdata,
    output logic                                    mem_we,
    output logic [$clog2(store_bytes(IMAGE_SIDE))-1:0] mem_waddr,
    output logic [DATA_W-1:0]                       mem_wdata,
    output logic                                    mem_re,
    output logic [$clog2(store_bytes(IMAGE_SIDE))-1:0] mem_raddr,
    input  logic [DATA_W-1:0]                       mem_rdata
);

    localparam int ROW_BYTES   = (IMAGE_SIDE + 7) / 8;
    localparam int STORE_BYTES = store_bytes(IMAGE_SIDE);
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int CW          = $clog2(IMAGE_SIDE);
    localparam int TW          = CW + 3;
    localparam int COORD_MAX   = IMAGE_SIDE - 1;
    localparam int OUT_PAD     = M_TDATA_W - DATA_W - 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_PLAN   = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;
    localparam logic [2:0] ST_READ   = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    function automatic logic coord_ok(input logic [COORD_W-1:0] v);
        return !v[COORD_W-1] && (v[COORD_W-2:0] <= (COORD_W-1)'(COORD_MAX));
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;

    logic [COORD_W-1:0]  sx_reg, sy_reg, ex_reg, ey_reg;
    logic [RADDR_W-1:0]  rd_addr_reg;

    logic [COORD_W-1:0]  ax_reg, ay_reg, bx_reg, by_reg;
    logic                lr_reg, bt_reg, inrange_reg;
    logic [COORD_W-1:0]  dx_reg, dy_reg;

    logic                steep_reg, dir_reg;
    logic [CW-1:0]       major_reg, minor_reg, count_reg, cur_x_reg;
    logic [TW-1:0]       test_reg;
    logic [AW-1:0]       row_base_reg;

    logic                p_valid_reg, w_valid_reg;
    logic [AW-1:0]       p_addr_reg, w_addr_reg;
    logic [DATA_W-1:0]   p_mask_reg, w_data_reg;

    logic                res_read_reg, res_ok_reg;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_read_data_reg;
    logic                m_drawn_reg;

    logic                accept;
    logic                out_load;

    logic [COORD_W-1:0]  ax_c, ay_c, bx_c, by_c;
    logic                lr_c, bt_c;
    logic [COORD_W:0]    dx_c, dy_c;

    logic                steep_c, use_a_c, dir_c;
    logic [CW-1:0]       start_x_c, start_y_c, major_c, minor_c;
    logic [TW-1:0]       test_init_c;
    logic [AW-1:0]       row_init_c;

    logic [TW-1:0]       t_step, t_keep;
    logic                t_pos;
    logic [AW-1:0]       pix_addr;
    logic [DATA_W-1:0]   pix_mask;
    logic [DATA_W-1:0]   merged;
    logic                rd_ok;

    assign accept   = (state_reg == ST_IDLE) && s_tvalid;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

    always_comb begin
        ax_c = landscape ? sy_reg : sx_reg;
        ay_c = landscape ? sx_reg : sy_reg;
        bx_c = landscape ? ey_reg : ex_reg;
        by_c = landscape ? ex_reg : ey_reg;
        lr_c = $signed(bx_c) >= $signed(ax_c);
        bt_c = $signed(by_c) >= $signed(ay_c);
        dx_c = lr_c ? ({bx_c[COORD_W-1], bx_c} - {ax_c[COORD_W-1], ax_c})
                    : ({ax_c[COORD_W-1], ax_c} - {bx_c[COORD_W-1], bx_c});
        dy_c = bt_c ? ({by_c[COORD_W-1], by_c} - {ay_c[COORD_W-1], ay_c})
                    : ({ay_c[COORD_W-1], ay_c} - {by_c[COORD_W-1], by_c});
    end

    always_comb begin
        steep_c     = dx_reg < dy_reg;
        use_a_c     = steep_c ? bt_reg : lr_reg;
        dir_c       = steep_c ? (bt_reg ? lr_reg : !lr_reg) : (lr_reg ? bt_reg : !bt_reg);
        start_x_c   = use_a_c ? ax_reg[CW-1:0] : bx_reg[CW-1:0];
        start_y_c   = use_a_c ? ay_reg[CW-1:0] : by_reg[CW-1:0];
        major_c     = steep_c ? dy_reg[CW-1:0] : dx_reg[CW-1:0];
        minor_c     = steep_c ? dx_reg[CW-1:0] : dy_reg[CW-1:0];
        test_init_c = TW'(minor_c) - TW'(major_c >> 1);
        row_init_c  = AW'(start_y_c) * AW'(ROW_BYTES);
    end

    always_comb begin
        t_step   = test_reg + TW'(minor_reg) - TW'(major_reg);
        t_keep   = test_reg + TW'(minor_reg);
        t_pos    = !t_step[TW-1] && (t_step != '0);
        pix_addr = row_base_reg + AW'(cur_x_reg >> 3);
        pix_mask = 8'h80 >> cur_x_reg[2:0];
        rd_ok    = 32'(rd_addr_reg) < STORE_BYTES;
    end

    // The previous write lands in the same cycle as this pixel's read, so
    // a repeat of that byte takes the written value instead of the RAM data.
    assign merged = ((w_valid_reg && (w_addr_reg == p_addr_reg)) ? w_data_reg : mem_rdata)
                    | p_mask_reg;

    always_comb begin
        mem_we    = (state_reg == ST_CLEAR) || p_valid_reg;
        mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : p_addr_reg;
        mem_wdata = (state_reg == ST_CLEAR) ? '0 : merged;
        mem_re    = (state_reg == ST_WALK) || (state_reg == ST_READ);
        mem_raddr = (state_reg == ST_WALK) ? pix_addr : AW'(rd_addr_reg);
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        m_valid_next  = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(STORE_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser[0] == FUNC_READ) ? ST_READ : ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = ST_PLAN;
            end
            ST_PLAN: begin
                state_next = inrange_reg ? ST_WALK : ST_FINISH;
            end
            ST_WALK: begin
                if (count_reg == '0) begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
            p_valid_reg  <= 1'b0;
            w_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
            p_valid_reg  <= (state_reg == ST_WALK);
            w_valid_reg  <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sx_reg       <= s_tdata[SX_LSB +: COORD_W];
            sy_reg       <= s_tdata[SY_LSB +: COORD_W];
            ex_reg       <= s_tdata[EX_LSB +: COORD_W];
            ey_reg       <= s_tdata[EY_LSB +: COORD_W];
            rd_addr_reg  <= s_tdata[RA_LSB +: RADDR_W];
            res_read_reg <= (s_tuser[0] == FUNC_READ);
        end
        if (state_reg == ST_SETUP) begin
            ax_reg      <= ax_c;
            ay_reg      <= ay_c;
            bx_reg      <= bx_c;
            by_reg      <= by_c;
            lr_reg      <= lr_c;
            bt_reg      <= bt_c;
            dx_reg      <= dx_c[COORD_W-1:0];
            dy_reg      <= dy_c[COORD_W-1:0];
            inrange_reg <= coord_ok(ax_c) && coord_ok(ay_c) && coord_ok(bx_c) && coord_ok(by_c);
        end
        if (state_reg == ST_PLAN) begin
            steep_reg    <= steep_c;
            dir_reg      <= dir_c;
            major_reg    <= major_c;
            minor_reg    <= minor_c;
            count_reg    <= major_c;
            test_reg     <= test_init_c;
            cur_x_reg    <= start_x_c;
            row_base_reg <= row_init_c;
            res_ok_reg   <= inrange_reg;
        end
        if (state_reg == ST_READ) begin
            res_ok_reg <= rd_ok;
        end
        if (state_reg == ST_WALK) begin
            p_addr_reg <= pix_addr;
            p_mask_reg <= pix_mask;
            count_reg  <= count_reg - 1'b1;
            test_reg   <= t_pos ? t_step : t_keep;
            if (steep_reg) begin
                row_base_reg <= row_base_reg + AW'(ROW_BYTES);
                if (t_pos) begin
                    cur_x_reg <= dir_reg ? cur_x_reg + 1'b1 : cur_x_reg - 1'b1;
                end
            end else begin
                cur_x_reg <= cur_x_reg + 1'b1;
                if (t_pos) begin
                    row_base_reg <= dir_reg ? row_base_reg + AW'(ROW_BYTES)
                                            : row_base_reg - AW'(ROW_BYTES);
                end
            end
        end
        w_addr_reg <= p_addr_reg;
        w_data_reg <= merged;
        if (out_load) begin
            m_read_data_reg <= (res_read_reg && res_ok_reg) ? mem_rdata : '0;
            m_drawn_reg     <= !res_read_reg && res_ok_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, m_drawn_reg, m_read_data_reg};

endmodule

FILE: design/bitmap_line_rasterizer.sv
// Top level of the bitmap line rasterizer: register port, engine and store.
// Depends on bmr_pkg, bmr_engine and bmr_ram.
//
// Channel  Direction  Handshake                  Payload
// s_       in         s_tvalid / s_tready        s_tdata, s_tuser (func)
// m_       out        m_tvalid / m_tready        m_tdata (read_data, drawn)
// cfg      in         psel, penable, pwrite      paddr, pwdata, prdata
//
// A draw item passes the setup states ST_SETUP and ST_PLAN, then one store
// read-modify-write per pixel through the single read and write ports, and
// ST_FINISH to load the result. A rejected segment goes from ST_PLAN to
// ST_FINISH, a read item through ST_READ and ST_FINISH. After reset the
// store is cleared one byte a cycle (8192 bytes at the default size)
// before the first item is taken; register writes go on.
// A result waiting on m_tready holds the block only at its result stage.

module bitmap_line_rasterizer import bmr_pkg::*; #(
    parameter int IMAGE_SIDE = IMAGE_SIDE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48],
    // read_address[76:64], zero [79:77]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // func[0]
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // read_data[7:0], drawn[8], zero [15:9]
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int STORE_BYTES = store_bytes(IMAGE_SIDE);
    localparam int AW          = $clog2(STORE_BYTES);

    logic              landscape_reg;
    logic              reg_index;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign prdata    = (reg_index == REG_LANDSCAPE) ? {31'b0, landscape_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            landscape_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && (reg_index == REG_LANDSCAPE)) begin
            landscape_reg <= pwdata[0];
        end
    end

    bmr_engine #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .landscape (landscape_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bmr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
